[sv/psr_pkg.sv]
// Package for the prime range sum sieve.
// Holds shared widths, the default sieve limit and the controller state type.
// No dependencies.
package psr_pkg;

	// default largest number the sieve covers
	localparam int unsigned PSR_MAX_LIMIT = 65535;

	// fixed field widths
	localparam int unsigned BOUND_W = 16;
	localparam int unsigned SUM_W   = 48;

	// controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_SV_RD,
		ST_SV_CHK,
		ST_STRIKE,
		ST_SCAN,
		ST_DONE
	} psr_state_t;

endpackage

[sv/prime_sum_in_range_sieve.sv]
// Prime range sum: sums every prime in [lower_bound, upper_bound].
// Command port: a transfer happens at a clock edge with start high and busy low.
// The result is shown on prime_sum for the single cycle in which done is high;
// the receiver takes it there and cannot hold it off.
// Internally a bitmap of odd numbers (number 2k+1 at entry k) lives in one
// synchronous RAM with a registered read port. Each non-empty command runs:
//   clear  : entries 1..L/2 written to zero, one per cycle
//   sieve  : for odd i from 3 with i*i <= L, read the entry of i, and if it is
//            unmarked strike i*i, i*i+2i, ... one write per cycle
//   scan   : odd n in 3..L read, one per cycle; unmarked n >= lower_bound summed
// where L is upper_bound saturated to MAX_LIMIT. Even numbers need no
// storage: 2 is added on its own.
// An empty range (lower_bound > upper_bound) shows its sum of 0 in the
// cycle right after the transfer. Only one command is in flight; busy stays
// high until done, and the next command is taken from the cycle after done.
// Reset clears the controller; the RAM needs no reset since every
// command rewrites the entries it reads.
module prime_sum_in_range_sieve #(
	parameter int unsigned MAX_LIMIT = psr_pkg::PSR_MAX_LIMIT
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [psr_pkg::BOUND_W-1:0] lower_bound,
	input  logic [psr_pkg::BOUND_W-1:0] upper_bound,
	output logic                        done,
	output logic [psr_pkg::SUM_W-1:0]   prime_sum
);
	import psr_pkg::*;

	// widths derived from the limit
	localparam int unsigned LW        = $clog2(MAX_LIMIT + 1);
	localparam int unsigned AW        = LW - 1;
	localparam int unsigned MAP_DEPTH = MAX_LIMIT / 2 + 1;
	localparam int unsigned SW        = LW + 2;
	localparam int unsigned NW        = LW + 1;
	localparam int unsigned CW        = (LW > BOUND_W) ? LW : BOUND_W;

	psr_state_t state_q, state_d;

	logic [BOUND_W-1:0] lower_q;
	logic [LW-1:0]      limit_q;
	logic [AW:0]        cnt_q;
	logic [LW-1:0]      i_q;
	logic [SW-1:0]      sq_q;
	logic [SW-1:0]      j_q;
	logic [NW-1:0]      n_q;
	logic [NW-1:0]      n_s1;
	logic               vld_s1;
	logic [SUM_W-1:0]   sum_q;

	// bitmap RAM
	logic               map_mem [MAP_DEPTH];
	logic               rd_q;
	logic               mem_we;
	logic               mem_re;
	logic               mem_wdata;
	logic [AW-1:0]      mem_addr;

	// accept-time decode
	logic               accept;
	logic [LW-1:0]      limit_in;
	logic               empty_in;
	logic               two_in;

	// loop conditions
	logic               clr_go;
	logic               sv_go;
	logic               strike_go;
	logic               scan_go;

	assign accept = start && (state_q == ST_IDLE);

	// saturate the upper bound to the sieve limit
	always_comb begin
		if (CW'(upper_bound) > CW'(MAX_LIMIT)) begin
			limit_in = LW'(MAX_LIMIT);
		end else begin
			limit_in = LW'(CW'(upper_bound));
		end
	end

	assign empty_in = lower_bound > upper_bound;
	assign two_in   = (limit_in >= LW'(2)) && (lower_bound <= BOUND_W'(2));

	assign clr_go    = cnt_q <= (AW + 1)'(limit_q[LW-1:1]);
	assign sv_go     = sq_q <= SW'(limit_q);
	assign strike_go = j_q <= SW'(limit_q);
	assign scan_go   = n_q <= NW'(limit_q);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and RAM control
	always_comb begin
		state_d   = state_q;
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		mem_wdata = 1'b0;
		mem_addr  = cnt_q[AW-1:0];
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = empty_in ? ST_DONE : ST_CLEAR;
				end
			end
			ST_CLEAR: begin
				if (clr_go) begin
					mem_we = 1'b1;
				end else begin
					state_d = ST_SV_RD;
				end
			end
			ST_SV_RD: begin
				mem_addr = i_q[LW-1:1];
				if (sv_go) begin
					mem_re  = 1'b1;
					state_d = ST_SV_CHK;
				end else begin
					state_d = ST_SCAN;
				end
			end
			ST_SV_CHK: begin
				state_d = rd_q ? ST_SV_RD : ST_STRIKE;
			end
			ST_STRIKE: begin
				mem_addr  = j_q[LW-1:1];
				mem_wdata = 1'b1;
				if (strike_go) begin
					mem_we = 1'b1;
				end else begin
					state_d = ST_SV_RD;
				end
			end
			ST_SCAN: begin
				mem_addr = n_q[LW-1:1];
				if (scan_go) begin
					mem_re = 1'b1;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// bitmap write port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			map_mem[mem_addr] <= mem_wdata;
		end
	end

	// bitmap read port, registered
	always_ff @(posedge clk) begin
		if (mem_re) begin
			rd_q <= map_mem[mem_addr];
		end
	end

	// scan pipeline valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= (state_q == ST_SCAN) && scan_go;
		end
	end

	// loop counters and accumulator
	always_ff @(posedge clk) begin
		n_s1 <= n_q;
		if (accept) begin
			lower_q <= lower_bound;
			limit_q <= limit_in;
			cnt_q   <= (AW + 1)'(1);
			i_q     <= LW'(3);
			sq_q    <= SW'(9);
			n_q     <= NW'(3);
			sum_q   <= (!empty_in && two_in) ? SUM_W'(2) : '0;
		end else begin
			if (state_q == ST_CLEAR && clr_go) begin
				cnt_q <= cnt_q + (AW + 1)'(1);
			end
			if (state_q == ST_SV_RD && sv_go) begin
				j_q <= sq_q;
			end
			// advance to the next odd candidate
			if ((state_q == ST_SV_CHK && rd_q) || (state_q == ST_STRIKE && !strike_go)) begin
				i_q  <= i_q + LW'(2);
				sq_q <= sq_q + SW'({i_q, 2'b00}) + SW'(4);
			end
			if (state_q == ST_STRIKE && strike_go) begin
				j_q <= j_q + SW'({i_q, 1'b0});
			end
			if (state_q == ST_SCAN && scan_go) begin
				n_q <= n_q + NW'(2);
			end
			// add each unmarked odd number inside the range
			if (vld_s1 && !rd_q && ((CW + 1)'(n_s1) >= (CW + 1)'(lower_q))) begin
				sum_q <= sum_q + SUM_W'(n_s1);
			end
		end
	end

	assign busy      = state_q != ST_IDLE;
	assign done      = state_q == ST_DONE;
	assign prime_sum = sum_q;

endmodule

[sv/psr_checker.sv]
// Port-level checks for the prime range sum sieve.
// Depends on psr_pkg; bound to prime_sum_in_range_sieve below.
module psr_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        start,
	input logic                        busy,
	input logic                        done,
	input logic [psr_pkg::SUM_W-1:0]   prime_sum
);
	import psr_pkg::*;

	// a result only ever ends a running command
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("done without busy");

	// the result strobe lasts one cycle
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held for more than one cycle");

	// an accepted command makes the block busy
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("command transfer did not raise busy");

	// the block is free right after it delivers
	a_done_free: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy)
		else $error("busy after result transfer");

	// every bit of the delivered sum is known
	a_sum_known: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !$isunknown(prime_sum))
		else $error("unknown sum delivered");

endmodule

bind prime_sum_in_range_sieve psr_checker u_psr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.done      (done),
	.prime_sum (prime_sum)
);
